[design/qbp_pkg.sv]
// shared constants, types and controller codes for the quadratic bezier point core
`default_nettype none

package qbp_pkg;

    localparam int COORD_WIDTH    = 32;
    localparam int SEG_W          = 6;
    localparam int MAX_SEGMENTS   = 63;
    localparam int RESET_SEGMENTS = 10;
    localparam int SQ_W           = 2 * SEG_W;
    localparam int FRAC_W         = 16;
    localparam int WEIGHT_W       = FRAC_W + 1;
    localparam int WEIGHT_ONE     = 1 << FRAC_W;
    localparam int ROUND_HALF     = 1 << (FRAC_W - 1);
    localparam int NUM_W          = SQ_W + FRAC_W;
    localparam int MUL_W          = WEIGHT_W + 1 + COORD_WIDTH;
    localparam int ACC_W          = MUL_W + 2;
    localparam int STEP_W         = $clog2(WEIGHT_W);
    localparam int DIV_LAST       = WEIGHT_W - 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_WRITE
    } state_t;

    typedef enum logic [1:0] {
        TERM_START,
        TERM_MID,
        TERM_END
    } term_t;

    typedef struct packed {
        logic  load_item;
        logic  setup;
        logic  div_step;
        logic  mul_en;
        term_t term;
        logic  acc_add;
        logic  write_out;
    } cmd_t;

    typedef struct packed {
        logic last_point;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[design/quadratic_bezier_points_core.sv]
// each point passes through setup, division, multiply, accumulate and write, in that order
// one curve of N+1 points is computed at a time, N the segment count; the input stalls until its last point is written
// each point runs the two restoring weight dividers, then the shared multipliers over the three terms
// a new curve is taken while the last point of the previous one waits in the output register
// reset: asynchronous active low, clears control state and sets the segment count to 10
`default_nettype none

module quadratic_bezier_points_core (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cfg_write,
    input  wire logic [qbp_pkg::SEG_W-1:0]               cfg_data,
    input  wire logic                                    in_valid,
    output logic                                         in_stall,
    input  wire logic signed [qbp_pkg::COORD_WIDTH-1:0]  start_x,
    input  wire logic signed [qbp_pkg::COORD_WIDTH-1:0]  start_y,
    input  wire logic signed [qbp_pkg::COORD_WIDTH-1:0]  mid_x,
    input  wire logic signed [qbp_pkg::COORD_WIDTH-1:0]  mid_y,
    input  wire logic signed [qbp_pkg::COORD_WIDTH-1:0]  end_x,
    input  wire logic signed [qbp_pkg::COORD_WIDTH-1:0]  end_y,
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output logic signed [qbp_pkg::COORD_WIDTH-1:0]       point_x,
    output logic signed [qbp_pkg::COORD_WIDTH-1:0]       point_y,
    output logic [qbp_pkg::SEG_W-1:0]                    point_index,
    output logic                                         last_point
);

    qbp_pkg::cmd_t    cmd;
    qbp_pkg::status_t status;

    qbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    qbp_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .start_x     (start_x),
        .start_y     (start_y),
        .mid_x       (mid_x),
        .mid_y       (mid_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_index (point_index),
        .last_point  (last_point)
    );

endmodule

`default_nettype wire

[design/qbp_datapath.sv]
// datapath: segment register, weight dividers, shared multipliers, accumulators, output register
`default_nettype none

module qbp_datapath (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cfg_write,
    input  wire logic [qbp_pkg::SEG_W-1:0]               cfg_data,
    input  wire logic signed [qbp_pkg::COORD_WIDTH-1:0]  start_x,
    input  wire logic signed [qbp_pkg::COORD_WIDTH-1:0]  start_y,
    input  wire logic signed [qbp_pkg::COORD_WIDTH-1:0]  mid_x,
    input  wire logic signed [qbp_pkg::COORD_WIDTH-1:0]  mid_y,
    input  wire logic signed [qbp_pkg::COORD_WIDTH-1:0]  end_x,
    input  wire logic signed [qbp_pkg::COORD_WIDTH-1:0]  end_y,
    input  wire qbp_pkg::cmd_t                           cmd,
    output qbp_pkg::status_t                             status,
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output logic signed [qbp_pkg::COORD_WIDTH-1:0]       point_x,
    output logic signed [qbp_pkg::COORD_WIDTH-1:0]       point_y,
    output logic [qbp_pkg::SEG_W-1:0]                    point_index,
    output logic                                         last_point
);

    localparam int CW = qbp_pkg::COORD_WIDTH;
    localparam int SW = qbp_pkg::SEG_W;
    localparam int QW = qbp_pkg::SQ_W;
    localparam int WW = qbp_pkg::WEIGHT_W;
    localparam int NW = qbp_pkg::NUM_W;
    localparam int FW = qbp_pkg::FRAC_W;
    localparam int MW = qbp_pkg::MUL_W;
    localparam int AW = qbp_pkg::ACC_W;

    logic [SW-1:0]        seg_reg;
    logic [SW-1:0]        n_eff;
    logic [SW-1:0]        n_reg;
    logic [QW-1:0]        n2_reg;
    logic [SW-1:0]        i_reg;
    logic signed [CW-1:0] p0x_reg, p0y_reg, p1x_reg, p1y_reg, p2x_reg, p2y_reg;

    logic [SW-1:0]        r_val;
    logic [QW-1:0]        sq_a, sq_c;
    logic [NW-1:0]        num_a, num_c;
    logic [QW-1:0]        rem_a_reg, rem_c_reg;
    logic [WW-1:0]        low_a_reg, low_c_reg;
    logic [WW-1:0]        qa_reg, qc_reg;
    logic [QW:0]          trial_a, trial_c;
    logic                 ge_a, ge_c;
    logic [WW-1:0]        wb;

    logic [WW-1:0]        w_sel;
    logic signed [CW-1:0] px_sel, py_sel;
    logic signed [MW-1:0] prod_x_reg, prod_y_reg;
    logic signed [AW-1:0] acc_x_reg, acc_y_reg;
    logic                 out_valid_reg;
    logic                 out_take;

    // segment count register, cleaned up for use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg <= SW'(qbp_pkg::RESET_SEGMENTS);
        end
        else if (cfg_write)
        begin
            seg_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (seg_reg == '0)
        begin
            n_eff = SW'(1);
        end
        else if (seg_reg > SW'(qbp_pkg::MAX_SEGMENTS))
        begin
            n_eff = SW'(qbp_pkg::MAX_SEGMENTS);
        end
        else
        begin
            n_eff = seg_reg;
        end
    end

    // divider numerators for the current point
    assign r_val   = n_reg - i_reg;
    assign sq_a    = QW'(r_val) * QW'(r_val);
    assign sq_c    = QW'(i_reg) * QW'(i_reg);
    assign num_a   = {sq_a, FW'(0)} + NW'(n2_reg >> 1);
    assign num_c   = {sq_c, FW'(0)} + NW'(n2_reg >> 1);

    assign trial_a = {rem_a_reg, low_a_reg[WW-1]};
    assign trial_c = {rem_c_reg, low_c_reg[WW-1]};
    assign ge_a    = trial_a >= {1'b0, n2_reg};
    assign ge_c    = trial_c >= {1'b0, n2_reg};

    assign wb = WW'(qbp_pkg::WEIGHT_ONE) - qa_reg - qc_reg;

    always_comb
    begin
        unique case (cmd.term)
            qbp_pkg::TERM_START:
            begin
                w_sel  = qa_reg;
                px_sel = p0x_reg;
                py_sel = p0y_reg;
            end
            qbp_pkg::TERM_MID:
            begin
                w_sel  = wb;
                px_sel = p1x_reg;
                py_sel = p1y_reg;
            end
            qbp_pkg::TERM_END:
            begin
                w_sel  = qc_reg;
                px_sel = p2x_reg;
                py_sel = p2y_reg;
            end
            default:
            begin
                w_sel  = '0;
                px_sel = '0;
                py_sel = '0;
            end
        endcase
    end

    // item registers and arithmetic payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            p0x_reg <= start_x;
            p0y_reg <= start_y;
            p1x_reg <= mid_x;
            p1y_reg <= mid_y;
            p2x_reg <= end_x;
            p2y_reg <= end_y;
            n_reg   <= n_eff;
            n2_reg  <= QW'(n_eff) * QW'(n_eff);
        end
        if (cmd.setup)
        begin
            rem_a_reg <= QW'(num_a[NW-1:WW]);
            rem_c_reg <= QW'(num_c[NW-1:WW]);
            low_a_reg <= num_a[WW-1:0];
            low_c_reg <= num_c[WW-1:0];
            qa_reg    <= '0;
            qc_reg    <= '0;
            acc_x_reg <= AW'(qbp_pkg::ROUND_HALF);
            acc_y_reg <= AW'(qbp_pkg::ROUND_HALF);
        end
        if (cmd.div_step)
        begin
            rem_a_reg <= ge_a ? QW'(trial_a - {1'b0, n2_reg}) : QW'(trial_a);
            rem_c_reg <= ge_c ? QW'(trial_c - {1'b0, n2_reg}) : QW'(trial_c);
            low_a_reg <= {low_a_reg[WW-2:0], 1'b0};
            low_c_reg <= {low_c_reg[WW-2:0], 1'b0};
            qa_reg    <= {qa_reg[WW-2:0], ge_a};
            qc_reg    <= {qc_reg[WW-2:0], ge_c};
        end
        if (cmd.mul_en)
        begin
            prod_x_reg <= $signed({1'b0, w_sel}) * px_sel;
            prod_y_reg <= $signed({1'b0, w_sel}) * py_sel;
        end
        if (cmd.acc_add)
        begin
            acc_x_reg <= acc_x_reg + AW'(prod_x_reg);
            acc_y_reg <= acc_y_reg + AW'(prod_y_reg);
        end
        if (cmd.write_out)
        begin
            point_x     <= acc_x_reg[FW +: CW];
            point_y     <= acc_y_reg[FW +: CW];
            point_index <= i_reg;
            last_point  <= (i_reg == n_reg);
        end
    end

    // point counter and output valid
    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                i_reg <= '0;
            end
            else if (cmd.write_out)
            begin
                i_reg <= i_reg + SW'(1);
            end
            if (cmd.write_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign status.last_point = (i_reg == n_reg);
    assign status.out_free   = !out_valid_reg || !out_stall;

endmodule

`default_nettype wire

[design/qbp_ctrl.sv]
// controller state machine sequencing setup, division, multiply and output per point
`default_nettype none

module qbp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire qbp_pkg::status_t  status,
    output qbp_pkg::cmd_t          cmd
);

    qbp_pkg::state_t                state_reg, state_next;
    logic [qbp_pkg::STEP_W-1:0]     step_reg, step_next;
    qbp_pkg::term_t                 term_reg, term_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qbp_pkg::ST_IDLE;
            step_reg  <= '0;
            term_reg  <= qbp_pkg::TERM_START;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            term_reg  <= term_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        term_next  = term_reg;
        unique case (state_reg)
            qbp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = qbp_pkg::ST_SETUP;
                end
            end
            qbp_pkg::ST_SETUP:
            begin
                step_next  = '0;
                term_next  = qbp_pkg::TERM_START;
                state_next = qbp_pkg::ST_DIV;
            end
            qbp_pkg::ST_DIV:
            begin
                step_next = step_reg + qbp_pkg::STEP_W'(1);
                if (step_reg == qbp_pkg::STEP_W'(qbp_pkg::DIV_LAST))
                begin
                    state_next = qbp_pkg::ST_MUL;
                end
            end
            qbp_pkg::ST_MUL:
            begin
                unique case (term_reg)
                    qbp_pkg::TERM_START: term_next = qbp_pkg::TERM_MID;
                    qbp_pkg::TERM_MID:   term_next = qbp_pkg::TERM_END;
                    qbp_pkg::TERM_END:   state_next = qbp_pkg::ST_ACC;
                    default:             state_next = qbp_pkg::ST_ACC;
                endcase
            end
            qbp_pkg::ST_ACC:
            begin
                state_next = qbp_pkg::ST_WRITE;
            end
            qbp_pkg::ST_WRITE:
            begin
                if (status.out_free)
                begin
                    state_next = status.last_point ? qbp_pkg::ST_IDLE : qbp_pkg::ST_SETUP;
                end
            end
            default:
            begin
                state_next = qbp_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        cmd.term  = term_reg;
        in_stall  = (state_reg != qbp_pkg::ST_IDLE);
        unique case (state_reg)
            qbp_pkg::ST_IDLE:  cmd.load_item = in_valid;
            qbp_pkg::ST_SETUP: cmd.setup     = 1'b1;
            qbp_pkg::ST_DIV:   cmd.div_step  = 1'b1;
            qbp_pkg::ST_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.acc_add = (term_reg != qbp_pkg::TERM_START);
            end
            qbp_pkg::ST_ACC:   cmd.acc_add   = 1'b1;
            qbp_pkg::ST_WRITE: cmd.write_out = status.out_free;
            default:           cmd           = '0;
        endcase
    end

endmodule

`default_nettype wire

[design/qbp_checker.sv]
// port-level checker for the quadratic bezier point core and its bind
`default_nettype none

module qbp_checker (
    input wire logic                                    clk,
    input wire logic                                    rst_n,
    input wire logic                                    in_valid,
    input wire logic                                    in_stall,
    input wire logic                                    out_valid,
    input wire logic                                    out_stall,
    input wire logic signed [qbp_pkg::COORD_WIDTH-1:0]  point_x,
    input wire logic signed [qbp_pkg::COORD_WIDTH-1:0]  point_y,
    input wire logic [qbp_pkg::SEG_W-1:0]               point_index,
    input wire logic                                    last_point
);

    // a stalled point holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y)
            && $stable(point_index) && $stable(last_point))
        else $error("stalled point changed");

    // a curve has at least one segment
    a_last_not_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_point |-> point_index != '0)
        else $error("last point flagged at index zero");

    // no new curve while an earlier one is unfinished
    a_busy_mid_curve: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_point |-> in_stall)
        else $error("input open in the middle of a curve");

    // a transfer on the input starts work
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after a transfer");

endmodule

bind quadratic_bezier_points_core qbp_checker u_qbp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_index (point_index),
    .last_point  (last_point)
);

`default_nettype wire
